// ===== design/assert_macros.svh =====
// assertion helpers included by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every edge, masked while reset is high
`define CHK_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every edge, reset included
`define CHK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/lpg_pkg.sv =====
package lpg_pkg;

  // register indexes on the config port
  localparam logic [0:0] REG_LAG_SAMPLES   = 1'd0;
  localparam logic [0:0] REG_USE_LAG_INPUT = 1'd1;

  // datapath operations, one per control word
  typedef enum logic [2:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_DIV_LOAD,
    OP_DIV_STEP,
    OP_UPDATE,
    OP_SNAP,
    OP_EMIT
  } op_t;

  // jump conditions
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_AT_TARGET,
    C_SHORT_LAG,
    C_DIV_BUSY,
    C_OUT_FULL
  } cond_t;

  typedef logic [3:0] pc_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } ucode_t;

  // flags the datapath reports to the sequencer
  typedef struct packed {
    logic no_input;
    logic at_target;
    logic short_lag;
    logic div_busy;
    logic out_full;
  } status_t;

  // program entry points
  localparam pc_t PC_IDLE = 4'd0;
  localparam pc_t PC_DIV  = 4'd4;
  localparam pc_t PC_SNAP = 4'd6;
  localparam pc_t PC_EMIT = 4'd7;

  // control store: jump to target when cond holds, else fall through
  function automatic ucode_t ucode_rom(input pc_t pc);
    ucode_t w;
    case (pc)
      4'd0:    w = '{op: OP_ACCEPT,   cond: C_NO_INPUT,  target: PC_IDLE};
      4'd1:    w = '{op: OP_NONE,     cond: C_AT_TARGET, target: PC_EMIT};
      4'd2:    w = '{op: OP_NONE,     cond: C_SHORT_LAG, target: PC_SNAP};
      4'd3:    w = '{op: OP_DIV_LOAD, cond: C_NEVER,     target: PC_IDLE};
      4'd4:    w = '{op: OP_DIV_STEP, cond: C_DIV_BUSY,  target: PC_DIV};
      4'd5:    w = '{op: OP_UPDATE,   cond: C_ALWAYS,    target: PC_EMIT};
      4'd6:    w = '{op: OP_SNAP,     cond: C_NEVER,     target: PC_IDLE};
      4'd7:    w = '{op: OP_EMIT,     cond: C_OUT_FULL,  target: PC_EMIT};
      default: w = '{op: OP_NONE,     cond: C_ALWAYS,    target: PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== design/lpg_sequencer.sv =====
module lpg_sequencer import lpg_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  status_t status,
  output op_t     op
);

  pc_t    pc;
  pc_t    pc_next;
  ucode_t word;
  logic   take;

  // fetch and branch decision
  always_comb begin
    word = ucode_rom(pc);
    case (word.cond)
      C_NEVER:     take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_NO_INPUT:  take = status.no_input;
      C_AT_TARGET: take = status.at_target;
      C_SHORT_LAG: take = status.short_lag;
      C_DIV_BUSY:  take = status.div_busy;
      C_OUT_FULL:  take = status.out_full;
      default:     take = 1'b0;
    endcase
    pc_next = take ? word.target : pc + pc_t'(1);
    op      = word.op;
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// ===== design/lpg_datapath.sv =====
module lpg_datapath import lpg_pkg::*; #(
  parameter int SAMPLE_WIDTH = 32,
  parameter int LAG_WIDTH    = 24,
  localparam int IN_W  = ((SAMPLE_WIDTH + LAG_WIDTH + 7) / 8) * 8,
  localparam int OUT_W = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  op_t                  op,
  output status_t              status,
  input  logic                 cfg_we,
  input  logic [0:0]           cfg_index,
  input  logic [LAG_WIDTH-1:0] cfg_data,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IN_W-1:0]      s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OUT_W-1:0]     m_axis_tdata
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int LW = LAG_WIDTH;
  localparam int CW = $clog2(SW);

  // config registers
  logic [LW-1:0] lag_samples;
  logic          use_lag_input;

  // glide state
  logic signed [SW-1:0] glide_start;
  logic signed [SW-1:0] glide_target;
  logic signed [SW-1:0] current_value;
  logic [LW-1:0]        lag_reg;

  // divider
  logic          diff_neg;
  logic [LW-1:0] rem;
  logic [SW-1:0] quo;
  logic [CW-1:0] div_cnt;

  // output register
  logic          out_valid;
  logic [SW-1:0] out_data;

  logic signed [SW-1:0] in_target;
  logic [LW-1:0]        in_lag;
  logic                 accept;
  logic                 emit;
  logic signed [SW:0]   diff;
  logic [SW:0]          diff_abs;
  logic [LW:0]          trial;
  logic [LW:0]          trial_sub;
  logic                 trial_ge;
  logic signed [SW+1:0] step;
  logic signed [SW+1:0] cur_ext;
  logic signed [SW+1:0] tgt_ext;
  logic signed [SW+1:0] sum;
  logic signed [SW+1:0] next_val;

  assign in_target = s_axis_tdata[SW-1:0];
  assign in_lag    = s_axis_tdata[SW+LW-1:SW];

  // no item is taken while reset is held
  assign s_axis_tready = (op == OP_ACCEPT) && !rst;
  assign accept        = s_axis_tready && s_axis_tvalid;
  assign emit          = (op == OP_EMIT) && !(out_valid && !m_axis_tready);

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_W'(out_data);

  // flags for the sequencer
  assign status.no_input  = !s_axis_tvalid;
  assign status.at_target = (current_value == glide_target);
  assign status.short_lag = (lag_reg[LW-1:1] == '0);
  assign status.div_busy  = (div_cnt != '0);
  assign status.out_full  = out_valid && !m_axis_tready;

  // glide span and its magnitude
  always_comb begin
    diff     = {glide_target[SW-1], glide_target} - {glide_start[SW-1], glide_start};
    diff_abs = diff[SW] ? -diff : diff;
  end

  // one restoring divide bit
  always_comb begin
    trial     = {rem, quo[SW-1]};
    trial_ge  = (trial >= {1'b0, lag_reg});
    trial_sub = trial - {1'b0, lag_reg};
  end

  // signed step, minimum of one lsb, clamp at target
  always_comb begin
    cur_ext = {{2{current_value[SW-1]}}, current_value};
    tgt_ext = {{2{glide_target[SW-1]}}, glide_target};
    if (quo == '0) begin
      step = (glide_target > current_value) ? (SW+2)'(1) : -(SW+2)'(1);
    end else if (diff_neg) begin
      step = -{2'b00, quo};
    end else begin
      step = {2'b00, quo};
    end
    sum = cur_ext + step;
    next_val = sum;
    if (glide_start <= glide_target) begin
      if (sum > tgt_ext) next_val = tgt_ext;
    end else begin
      if (sum < tgt_ext) next_val = tgt_ext;
    end
  end

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      lag_samples   <= '0;
      use_lag_input <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LAG_SAMPLES:   lag_samples   <= cfg_data;
        REG_USE_LAG_INPUT: use_lag_input <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // glide state
  always_ff @(posedge clk) begin
    if (rst) begin
      glide_start   <= '0;
      glide_target  <= '0;
      current_value <= '0;
    end else begin
      if (accept && (in_target != glide_target)) begin
        glide_target <= in_target;
        glide_start  <= current_value;
      end
      if (op == OP_SNAP) begin
        current_value <= glide_target;
      end else if (op == OP_UPDATE) begin
        current_value <= next_val[SW-1:0];
      end
    end
  end

  // item lag and divider registers
  always_ff @(posedge clk) begin
    if (accept) begin
      lag_reg <= use_lag_input ? in_lag : lag_samples;
    end
    if (op == OP_DIV_LOAD) begin
      rem      <= '0;
      quo      <= diff_abs[SW-1:0];
      diff_neg <= diff[SW];
      div_cnt  <= CW'(SW - 1);
    end else if (op == OP_DIV_STEP) begin
      rem     <= trial_ge ? trial_sub[LW-1:0] : trial[LW-1:0];
      quo     <= {quo[SW-2:0], trial_ge};
      div_cnt <= div_cnt - CW'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= current_value;
    end
  end

endmodule

// ===== design/linear_portamento_glide_top.sv =====
// linear portamento glide, signed fixed-point samples
// input stream: one target sample plus a per-item lag; output stream: one
// glided sample for every input item, in order.
// a target change restarts the glide from the present output; each item then
// moves the output by (target - start) / lag, at least one lsb, clamped at
// the target. lag 0 or 1 jumps straight to the target.
// config port: register 0 is the fixed lag, register 1 selects the per-item
// lag (reset value 1); write only while the block is idle.
// items are taken one at a time; while gliding, an item runs the bit-per-cycle
// restoring divider, and items already at target or with a short lag skip it.
// a gliding item passes the divider load, the divider steps, the update and
// the emit step before its output turns valid.
// s_axis_tready is high only in the microcode's accept step; a pending
// output may wait in its register while the next item is accepted.
// a stalled receiver holds the sequencer at its emit step, holding the input.
// reset (synchronous) clears the glide state and the output valid and resets the config.
module linear_portamento_glide_top import lpg_pkg::*; #(
  parameter int SAMPLE_WIDTH = 32,
  parameter int LAG_WIDTH    = 24,
  localparam int IN_W  = ((SAMPLE_WIDTH + LAG_WIDTH + 7) / 8) * 8,
  localparam int OUT_W = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [0:0]           cfg_index,
  input  logic [LAG_WIDTH-1:0] cfg_data,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IN_W-1:0]      s_axis_tdata,   // target_sample, lag_input
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OUT_W-1:0]     m_axis_tdata    // out_sample
);

  op_t     op;
  status_t status;

  // microcode step counter and control store
  lpg_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .op     (op)
  );

  // glide registers, divider and stream ports
  lpg_datapath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .LAG_WIDTH    (LAG_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .op            (op),
    .status        (status),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// ===== design/lpg_checker.sv =====
`include "assert_macros.svh"

module lpg_checker #(
  parameter int SAMPLE_WIDTH = 32,
  parameter int LAG_WIDTH    = 24,
  localparam int IN_W  = ((SAMPLE_WIDTH + LAG_WIDTH + 7) / 8) * 8,
  localparam int OUT_W = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 cfg_we,
  input logic [0:0]           cfg_index,
  input logic [LAG_WIDTH-1:0] cfg_data,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic [IN_W-1:0]      s_axis_tdata,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [OUT_W-1:0]     m_axis_tdata
);

  // reset empties the output register
  `CHK_ASSERT_ALWAYS(a_rst_out, clk, rst |=> !m_axis_tvalid, "output valid after reset")

  // one item at a time: ready drops right after an accept
  `CHK_ASSERT(a_one_item, clk, rst, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "ready held after accept")

  // a new result never shows while the sequencer waits for input
  `CHK_ASSERT(a_emit_step, clk, rst, $rose(m_axis_tvalid) |-> !s_axis_tready, "result shown in accept step")

  // stalled result holds
  `CHK_ASSERT(a_out_hold, clk, rst, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)), "stalled result changed")

endmodule

bind linear_portamento_glide_top lpg_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH),
  .LAG_WIDTH    (LAG_WIDTH)
) u_lpg_checker (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top import lpg_pkg::*;;

  localparam int SAMPLE_W     = 32;
  localparam int LAG_W        = 24;
  localparam int IN_W         = ((SAMPLE_W + LAG_W + 7) / 8) * 8;
  localparam int OUT_W        = ((SAMPLE_W + 7) / 8) * 8;
  localparam int DRAIN_CYCLES = SAMPLE_W + 16;
  localparam int HOLD_CYCLES  = 600;

  localparam logic [LAG_W-1:0]    LAG_MAX    = '1;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  logic             clk           = 1'b0;
  logic             rst           = 1'b1;
  logic             cfg_we        = 1'b0;
  logic [0:0]       cfg_index     = '0;
  logic [LAG_W-1:0] cfg_data      = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata  = '0;  // target_sample, lag_input
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;        // out_sample

  // glide state as the block should hold it
  logic signed [SAMPLE_W-1:0] glide_from   = '0;
  logic signed [SAMPLE_W-1:0] glide_to     = '0;
  logic signed [SAMPLE_W-1:0] glide_now    = '0;
  logic [LAG_W-1:0]           fixed_lag    = '0;
  logic                       use_item_lag = 1'b1;

  logic [OUT_W-1:0] expected_out[$];
  logic [OUT_W-1:0] want;

  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  int n_items       = 0;
  int n_checked     = 0;
  int n_errors      = 0;
  int n_writes      = 0;
  int n_jumps       = 0;
  int n_lsb_steps   = 0;
  int n_clamps      = 0;

  // receiver hold-off request and its own cycle count
  bit hold_req  = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  linear_portamento_glide_top #(
    .SAMPLE_WIDTH(SAMPLE_W),
    .LAG_WIDTH   (LAG_W)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // advance the glide by one accepted item and queue the sample it yields
  function automatic void glide_predict(input logic [SAMPLE_W-1:0] tgt,
                                        input logic [LAG_W-1:0] lag_in);
    longint t, lag, diff, stepv, nxt, cur, st, tg;
    t   = longint'($signed(tgt));
    lag = use_item_lag ? longint'(lag_in) : longint'(fixed_lag);
    if (t != longint'(glide_to)) begin
      glide_to   = tgt;
      glide_from = glide_now;
    end
    cur = longint'(glide_now);
    tg  = longint'(glide_to);
    st  = longint'(glide_from);
    if (cur != tg) begin
      if (lag <= 1) begin
        cur = tg;
        n_jumps++;
      end else begin
        diff  = tg - st;
        stepv = diff / lag;
        // a step that truncates away still moves one lsb
        if (stepv == 0) begin
          stepv = (tg > cur) ? 1 : -1;
          n_lsb_steps++;
        end
        nxt = cur + stepv;
        if (st <= tg) begin
          if (nxt > tg) begin
            nxt = tg;
            n_clamps++;
          end
        end else if (nxt < tg) begin
          nxt = tg;
          n_clamps++;
        end
        cur = nxt;
      end
      glide_now = cur[SAMPLE_W-1:0];
    end
    expected_out.push_back(OUT_W'(glide_now));
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_target();
    int roll;
    roll = $urandom_range(99);
    if (roll < 8) return SAMPLE_MAX;
    if (roll < 16) return SAMPLE_MIN;
    // near the present target, so glides stay short and overlap
    if (roll < 50) return glide_to + SAMPLE_W'(int'($urandom_range(4000)) - 2000);
    return $urandom;
  endfunction

  function automatic logic [LAG_W-1:0] pick_lag();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return LAG_W'($urandom_range(1));
    if (roll < 75) return LAG_W'($urandom_range(40, 2));
    if (roll < 88) return LAG_W'($urandom_range(4096, 41));
    if (roll < 95) return LAG_MAX;
    return LAG_W'($urandom);
  endfunction

  // offer one item, with a random gap first, and wait for its accept
  task automatic send_item(input logic [SAMPLE_W-1:0] tgt, input logic [LAG_W-1:0] lag);
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'({lag, tgt});
    do @(posedge clk); while (!s_axis_tready);
    glide_predict(tgt, lag);
    n_items++;
  endtask

  task automatic wait_drain();
    while (expected_out.size() != 0) @(posedge clk);
  endtask

  // register write once the block has gone idle
  task automatic write_reg(input logic [0:0] idx, input logic [LAG_W-1:0] val);
    s_axis_tvalid <= 1'b0;
    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_LAG_SAMPLES) fixed_lag = val;
    else use_item_lag = val[0];
    n_writes++;
  endtask

  // runs of a held target with random content, mixed with lone noise items
  task automatic run_glides(input int n);
    int sent;
    int run_len;
    logic [SAMPLE_W-1:0] tgt;
    logic [LAG_W-1:0]    lag;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(99) < 12) begin
        send_item($urandom, LAG_W'($urandom));
        sent++;
      end else begin
        tgt     = pick_target();
        lag     = pick_lag();
        run_len = $urandom_range(24, 1);
        for (int i = 0; i < run_len && sent < n; i++) begin
          if ($urandom_range(9) == 0) lag = pick_lag();
          send_item(tgt, lag);
          sent++;
        end
      end
    end
  endtask

  task automatic test_directed();
    // jumps to both extremes with lag 0 and 1
    send_item(SAMPLE_MAX, '0);
    send_item(SAMPLE_MIN, 24'd1);
    // full-scale glides up and down; the glide up ends clamped
    repeat (3) send_item(SAMPLE_MAX, 24'd2);
    repeat (4) send_item(SAMPLE_MIN, 24'd3);
    // steps that truncate to zero move one lsb each way
    send_item('0, 24'd1);
    repeat (3) send_item(32'sd5, LAG_MAX);
    repeat (3) send_item(-32'sd3, LAG_MAX);
    // short glide that overshoots and clamps, then sits at target
    repeat (5) send_item(32'sd100, 24'd3);
    // alternating bit patterns in both fields
    send_item(32'h5555_5555, 24'h55_5555);
    send_item(32'haaaa_aaaa, 24'haa_aaaa);
  endtask

  task automatic test_fixed_lag();
    logic [LAG_W-1:0] lags[5];
    lags = '{'0, 24'd1, 24'd2, 24'd5, LAG_MAX};
    write_reg(REG_USE_LAG_INPUT, '0);
    foreach (lags[k]) begin
      write_reg(REG_LAG_SAMPLES, lags[k]);
      // per-item lag field is random and must be ignored
      repeat (6) send_item(SAMPLE_MAX - 32'd77, LAG_W'($urandom));
      repeat (6) send_item(pick_target(), LAG_W'($urandom));
    end
  endtask

  task automatic run_phase(input int n, input int src_pct, input int snk_pct,
                           input logic item_mode, input logic [LAG_W-1:0] lag_cfg);
    write_reg(REG_USE_LAG_INPUT, LAG_W'(item_mode));
    write_reg(REG_LAG_SAMPLES, lag_cfg);
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    run_glides(n);
  endtask

  task automatic test_random_traffic();
    run_phase(330, 0, 0, 1'b1, '0);
    run_phase(330, 56, 0, 1'b0, 24'd12);
    run_phase(330, 0, 56, 1'b1, LAG_MAX);
    run_phase(330, 20, 20, 1'b0, 24'd3);
  endtask

  // receiver holds off while the sender keeps offering items
  task automatic test_backpressure();
    write_reg(REG_USE_LAG_INPUT, 24'd1);
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    hold_req      = !hold_req;
    run_glides(40);
  endtask

  // receiver: random stalls, or a long hold when requested
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen     <= hold_req;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // compare each accepted sample with the oldest expected one
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_out.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected sample %h", m_axis_tdata);
      end else begin
        want = expected_out.pop_front();
        n_checked++;
        if (m_axis_tdata !== want) begin
          n_errors++;
          if (n_errors <= 10)
            $display("sample %0d out_sample: expected %h got %h",
                     n_checked, want, m_axis_tdata);
        end
      end
    end
  end

  initial begin
    #8_000_000;
    $display("timeout with %0d samples outstanding", expected_out.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_fixed_lag();
    test_random_traffic();
    test_backpressure();
    s_axis_tvalid <= 1'b0;
    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_out.size() != 0)
      $display("%0d expected samples never arrived", expected_out.size());
    $display("covered %0d items, %0d samples checked, %0d register writes, %0d mismatches",
             n_items, n_checked, n_writes, n_errors);
    $display("glide cases: %0d lag jumps, %0d one-lsb steps, %0d clamps at target",
             n_jumps, n_lsb_steps, n_clamps);
    if (n_errors == 0 && expected_out.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
